@@ design/fir_pkg.sv @@
// Shared constants, types and the moving-average weight table for the FIR filter.
package fir_pkg;

   localparam int MAX_TAPS       = 16;
   localparam int SAMPLE_BITS    = 16;
   localparam int COEF_BITS      = 16;
   localparam int FRAC_BITS      = 14;
   localparam int TAP_IDX_BITS   = $clog2(MAX_TAPS);
   localparam int TAP_CNT_BITS   = 5;
   localparam int DIGIT_BITS     = 4;
   localparam int NUM_DIGITS     = COEF_BITS / DIGIT_BITS;
   localparam int DIGIT_IDX_BITS = $clog2(NUM_DIGITS);
   localparam int SHIFT_BITS     = $clog2(COEF_BITS);
   localparam int PROD_BITS      = SAMPLE_BITS + DIGIT_BITS + 1;
   localparam int ACC_BITS       = SAMPLE_BITS + COEF_BITS + TAP_IDX_BITS + 1;
   localparam int REQ_DATA_BITS  = 40;
   localparam int RSP_DATA_BITS  = 24;
   localparam int CSR_IDX_BITS   = 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_TAP_COUNT    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_AVERAGE_MODE = 2'd1;

   localparam logic [TAP_CNT_BITS-1:0] TAP_COUNT_RESET = TAP_CNT_BITS'(MAX_TAPS);

   localparam logic ACTION_FILTER = 1'b0;
   localparam logic ACTION_LOAD   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_MAC  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   typedef struct packed {
      logic                      clear;
      logic                      enable;
      logic                      top_digit;
      logic [DIGIT_IDX_BITS-1:0] digit_idx;
   } mac_ctrl_type;

   // round(16384 / n) for n = 1 .. 16, indexed by n - 1
   function automatic logic signed [COEF_BITS-1:0] avg_weight(
      input logic [TAP_IDX_BITS-1:0] n_minus1);
      logic signed [COEF_BITS-1:0] w;
      case (n_minus1)
         4'd0:    w = 16'sd16384;
         4'd1:    w = 16'sd8192;
         4'd2:    w = 16'sd5461;
         4'd3:    w = 16'sd4096;
         4'd4:    w = 16'sd3277;
         4'd5:    w = 16'sd2731;
         4'd6:    w = 16'sd2341;
         4'd7:    w = 16'sd2048;
         4'd8:    w = 16'sd1820;
         4'd9:    w = 16'sd1638;
         4'd10:   w = 16'sd1489;
         4'd11:   w = 16'sd1365;
         4'd12:   w = 16'sd1260;
         4'd13:   w = 16'sd1170;
         4'd14:   w = 16'sd1092;
         4'd15:   w = 16'sd1024;
         default: w = 16'sd1024;
      endcase
      return w;
   endfunction

endpackage

@@ design/fir_mac.sv @@
// Digit-serial multiply-accumulate: one coefficient digit times one sample per cycle.
module fir_mac (
   input  logic                                     clock,
   input  fir_pkg::mac_ctrl_type                    ctrl,
   input  logic signed [fir_pkg::SAMPLE_BITS-1:0]   sample,
   input  logic        [fir_pkg::DIGIT_BITS-1:0]    digit,
   output logic signed [fir_pkg::ACC_BITS-1:0]      acc
);

   logic signed [fir_pkg::ACC_BITS-1:0]   acc_ff;
   logic signed [fir_pkg::ACC_BITS-1:0]   acc_in;
   logic signed [fir_pkg::DIGIT_BITS:0]   digit_s;
   logic signed [fir_pkg::PROD_BITS-1:0]  prod;
   logic signed [fir_pkg::ACC_BITS-1:0]   prod_ext;
   logic        [fir_pkg::SHIFT_BITS-1:0] amount;

   always_comb begin
      // only the most significant digit of the coefficient carries the sign
      digit_s  = $signed({ctrl.top_digit & digit[fir_pkg::DIGIT_BITS-1], digit});
      prod     = sample * digit_s;
      prod_ext = fir_pkg::ACC_BITS'(prod);
      amount   = fir_pkg::SHIFT_BITS'(ctrl.digit_idx) *
                 fir_pkg::SHIFT_BITS'(fir_pkg::DIGIT_BITS);
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (ctrl.enable) begin
         acc_in = acc_ff + (prod_ext <<< amount);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

@@ design/fir_filter_core.sv @@
// Top level of the direct-form FIR filter with a digit-serial multiply-accumulate.
//
// Input channel req_: one item per handshake. req_tuser selects the action:
// 0 filters req_tdata's sample, 1 loads coef_value into tap coef_index.
// A load gives no result. A sample shifts the delay line and starts the
// multiply-accumulate, which walks the active taps one 4-bit coefficient digit
// per cycle, then rounds and saturates the sum. No new item, sample or load, is
// accepted until that result has moved into the output register: req_tready is
// high only while the block is idle.
// Result channel rsp_: one item per sample, held in an output register until
// taken. While it waits the block still accepts the next item; a stalled
// receiver only holds the block once the next result is ready to go out.
// Configuration port csr_: 0 tap_count, 1 average_mode, other indexes ignored.
// Write (csr_we high) only while the block is idle; the block does not check it.
// Reset (synchronous, active high) clears the delay line and coefficient store,
// sets tap_count to 16 and average_mode to 0, and empties the output register.
module fir_filter_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // sample[15:0], coef_index[19:16], coef_value[35:20], zero pad [39:36]
   input  logic [fir_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // action
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // filtered[15:0], saturated[16], zero pad [23:17]
   output logic [fir_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                                csr_we,
   input  logic [fir_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [fir_pkg::TAP_CNT_BITS-1:0]    csr_wdata
);

   localparam int MAX_TAPS = fir_pkg::MAX_TAPS;
   localparam int SB       = fir_pkg::SAMPLE_BITS;
   localparam int CB       = fir_pkg::COEF_BITS;
   localparam int TIB      = fir_pkg::TAP_IDX_BITS;
   localparam int TCB      = fir_pkg::TAP_CNT_BITS;
   localparam int DB       = fir_pkg::DIGIT_BITS;
   localparam int DIB      = fir_pkg::DIGIT_IDX_BITS;
   localparam int AB       = fir_pkg::ACC_BITS;
   localparam int FB       = fir_pkg::FRAC_BITS;
   localparam int RB       = AB - FB;

   fir_pkg::state_type state_ff, state_in;

   logic [TCB-1:0]        tap_count_ff, tap_count_in;
   logic                  average_mode_ff, average_mode_in;
   logic signed [SB-1:0]  delay_ff [MAX_TAPS];
   logic signed [SB-1:0]  delay_in [MAX_TAPS];
   logic signed [CB-1:0]  coef_ff  [MAX_TAPS];
   logic signed [CB-1:0]  coef_in  [MAX_TAPS];
   logic [TIB-1:0]        tap_ff, tap_in;
   logic [TIB-1:0]        last_tap_ff, last_tap_in;
   logic [DIB-1:0]        digit_ff, digit_in;
   logic signed [CB-1:0]  weight_ff, weight_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [SB-1:0]  filtered_ff, filtered_in;
   logic                  saturated_ff, saturated_in;

   logic                  req_accept;
   logic                  action;
   logic signed [SB-1:0]  req_sample;
   logic [TIB-1:0]        req_index;
   logic signed [CB-1:0]  req_coef;
   logic [TIB-1:0]        n_minus1;
   logic signed [CB-1:0]  coef_cur;
   logic [DB-1:0]         digit;
   logic                  mac_last;
   logic                  rsp_load;
   fir_pkg::mac_ctrl_type mac_ctrl;
   logic signed [AB-1:0]  acc;
   logic signed [AB-1:0]  rounded;
   logic signed [RB-1:0]  shifted;
   logic [RB-SB:0]        upper;

   assign action     = req_tuser;
   assign req_sample = $signed(req_tdata[SB-1:0]);
   assign req_index  = req_tdata[SB +: TIB];
   assign req_coef   = $signed(req_tdata[SB+TIB +: CB]);
   assign req_tready = (state_ff == fir_pkg::ST_IDLE);
   assign req_accept = req_tvalid & req_tready;

   // clamp the tap count into 1 .. MAX_TAPS
   always_comb begin
      if (tap_count_ff == '0) begin
         n_minus1 = '0;
      end else if (tap_count_ff > TCB'(MAX_TAPS)) begin
         n_minus1 = TIB'(MAX_TAPS - 1);
      end else begin
         n_minus1 = TIB'(tap_count_ff - 1'b1);
      end
   end

   always_comb begin
      coef_cur = average_mode_ff ? weight_ff : coef_ff[tap_ff];
      digit    = coef_cur[digit_ff*DB +: DB];
      mac_last = (tap_ff == last_tap_ff) && (digit_ff == DIB'(fir_pkg::NUM_DIGITS - 1));

      mac_ctrl.clear     = req_accept && (action == fir_pkg::ACTION_FILTER);
      mac_ctrl.enable    = (state_ff == fir_pkg::ST_MAC);
      mac_ctrl.top_digit = (digit_ff == DIB'(fir_pkg::NUM_DIGITS - 1));
      mac_ctrl.digit_idx = digit_ff;
   end

   fir_mac u_mac (
      .clock  (clock),
      .ctrl   (mac_ctrl),
      .sample (delay_ff[tap_ff]),
      .digit  (digit),
      .acc    (acc)
   );

   // round by half an LSB, floor shift, then clip to the sample range
   always_comb begin
      rounded = acc + AB'(1 << (FB - 1));
      shifted = rounded[AB-1:FB];
      upper   = shifted[RB-1:SB-1];
      if ((&upper) || !(|upper)) begin
         filtered_in  = shifted[SB-1:0];
         saturated_in = 1'b0;
      end else begin
         filtered_in  = shifted[RB-1] ? $signed({1'b1, {(SB-1){1'b0}}})
                                      : $signed({1'b0, {(SB-1){1'b1}}});
         saturated_in = 1'b1;
      end
   end

   always_comb begin
      state_in        = state_ff;
      tap_count_in    = tap_count_ff;
      average_mode_in = average_mode_ff;
      delay_in        = delay_ff;
      coef_in         = coef_ff;
      tap_in          = tap_ff;
      last_tap_in     = last_tap_ff;
      digit_in        = digit_ff;
      weight_in       = weight_ff;
      rsp_load        = 1'b0;

      if (csr_we) begin
         case (csr_index)
            fir_pkg::CSR_TAP_COUNT:    tap_count_in    = csr_wdata;
            fir_pkg::CSR_AVERAGE_MODE: average_mode_in = csr_wdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         fir_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (action == fir_pkg::ACTION_LOAD) begin
                  coef_in[req_index] = req_coef;
               end else begin
                  delay_in[0] = req_sample;
                  for (int i = 1; i < MAX_TAPS; i++) begin
                     delay_in[i] = delay_ff[i-1];
                  end
                  tap_in      = '0;
                  digit_in    = '0;
                  last_tap_in = n_minus1;
                  weight_in   = fir_pkg::avg_weight(n_minus1);
                  state_in    = fir_pkg::ST_MAC;
               end
            end
         end
         fir_pkg::ST_MAC: begin
            digit_in = digit_ff + 1'b1;
            if (digit_ff == DIB'(fir_pkg::NUM_DIGITS - 1)) begin
               tap_in = tap_ff + 1'b1;
            end
            if (mac_last) begin
               state_in = fir_pkg::ST_DONE;
            end
         end
         fir_pkg::ST_DONE: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = fir_pkg::ST_IDLE;
            end
         end
         default: state_in = fir_pkg::ST_IDLE;
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= fir_pkg::ST_IDLE;
         tap_count_ff    <= fir_pkg::TAP_COUNT_RESET;
         average_mode_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < MAX_TAPS; i++) begin
            delay_ff[i] <= '0;
            coef_ff[i]  <= '0;
         end
      end else begin
         state_ff        <= state_in;
         tap_count_ff    <= tap_count_in;
         average_mode_ff <= average_mode_in;
         rsp_valid_ff    <= rsp_valid_in;
         delay_ff        <= delay_in;
         coef_ff         <= coef_in;
      end
   end

   always_ff @(posedge clock) begin
      tap_ff      <= tap_in;
      last_tap_ff <= last_tap_in;
      digit_ff    <= digit_in;
      weight_ff   <= weight_in;
      if (rsp_load) begin
         filtered_ff  <= filtered_in;
         saturated_ff <= saturated_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(fir_pkg::RSP_DATA_BITS - SB - 1)'(0), saturated_ff, filtered_ff};

endmodule
